// ===== sv/spht_pkg.sv =====
package spht_pkg;

  // Default geometry
  localparam int COORD_BITS      = 12;
  localparam int SCALE_FRAC_BITS = 8;

  // Fixed register widths
  localparam int SCALE_W   = 16;
  localparam int MARGIN_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SCALE_W;

  localparam logic [MARGIN_W-1:0]   MARGIN_RST    = MARGIN_W'(4);
  localparam logic [2*MARGIN_W-1:0] MARGIN_SQ_RST = (2*MARGIN_W)'(16);
  localparam logic [SCALE_W-1:0]    SCALE_RST     = SCALE_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIT_MARGIN = 2'd0,
    CFG_X_SCALE    = 2'd1,
    CFG_Y_SCALE    = 2'd2
  } cfg_idx_e;

  // Per-word control that travels down the pipe
  typedef struct packed {
    logic vld;
    logic kind;      // 0 rectangle, 1 line
    logic rect_hit;  // valid from stage 2 on
  } spht_ctl_t;

endpackage

// ===== sv/spht_scale.sv =====
module spht_scale import spht_pkg::*; #(
  parameter int COORD_BITS_P = COORD_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [COORD_BITS_P-1:0]            pick_x_i,
  input  logic [COORD_BITS_P-1:0]            pick_y_i,
  input  logic                               obj_kind_i,
  input  logic [COORD_BITS_P-1:0]            obj_x1_i,
  input  logic [COORD_BITS_P-1:0]            obj_y1_i,
  input  logic [COORD_BITS_P-1:0]            obj_x2_i,
  input  logic [COORD_BITS_P-1:0]            obj_y2_i,
  input  logic [SCALE_W-1:0]                 x_scale_i,
  input  logic [SCALE_W-1:0]                 y_scale_i,
  output spht_ctl_t                          ctl_o,
  output logic [COORD_BITS_P-1:0]            px_o,
  output logic [COORD_BITS_P-1:0]            py_o,
  output logic [COORD_BITS_P+SCALE_W-1:0]    ax_o,
  output logic [COORD_BITS_P+SCALE_W-1:0]    ay_o,
  output logic [COORD_BITS_P+SCALE_W-1:0]    bx_o,
  output logic [COORD_BITS_P+SCALE_W-1:0]    by_o
);

  localparam int PW = COORD_BITS_P + SCALE_W;

  spht_ctl_t         ctl_d, ctl_q;
  logic [PW-1:0]     ax_d, ay_d, bx_d, by_d;
  logic [PW-1:0]     ax_q, ay_q, bx_q, by_q;
  logic [COORD_BITS_P-1:0] px_q, py_q;

  // corner * scale, full precision
  assign ax_d = PW'(obj_x1_i) * PW'(x_scale_i);
  assign bx_d = PW'(obj_x2_i) * PW'(x_scale_i);
  assign ay_d = PW'(obj_y1_i) * PW'(y_scale_i);
  assign by_d = PW'(obj_y2_i) * PW'(y_scale_i);

  always_comb begin
    ctl_d          = '0;
    ctl_d.vld      = accept_i;
    ctl_d.kind     = obj_kind_i;
    ctl_d.rect_hit = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= pick_x_i;
    py_q <= pick_y_i;
    ax_q <= ax_d;
    ay_q <= ay_d;
    bx_q <= bx_d;
    by_q <= by_d;
  end

  assign ctl_o = ctl_q;
  assign px_o  = px_q;
  assign py_o  = py_q;
  assign ax_o  = ax_q;
  assign ay_o  = ay_q;
  assign bx_o  = bx_q;
  assign by_o  = by_q;

endmodule

// ===== sv/spht_rect.sv =====
module spht_rect import spht_pkg::*; #(
  parameter int COORD_BITS_P      = COORD_BITS,
  parameter int SCALE_FRAC_BITS_P = SCALE_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  spht_ctl_t                          ctl_i,
  input  logic [COORD_BITS_P-1:0]            px_i,
  input  logic [COORD_BITS_P-1:0]            py_i,
  input  logic [COORD_BITS_P+SCALE_W-1:0]    ax_i,
  input  logic [COORD_BITS_P+SCALE_W-1:0]    ay_i,
  input  logic [COORD_BITS_P+SCALE_W-1:0]    bx_i,
  input  logic [COORD_BITS_P+SCALE_W-1:0]    by_i,
  input  logic [MARGIN_W-1:0]                margin_i,
  output spht_ctl_t                          ctl_o
);

  localparam int PW = COORD_BITS_P + SCALE_W;
  localparam int RW = PW + 2;

  logic signed [RW-1:0] p, q, m, ax, ay, bx, by;
  logic      in_x_span, in_y_span, y_band, x_band, hit;
  spht_ctl_t ctl_d, ctl_q;

  // pick point and margin moved into the fixed-point domain of the corners
  assign p  = RW'({px_i, {SCALE_FRAC_BITS_P{1'b0}}});
  assign q  = RW'({py_i, {SCALE_FRAC_BITS_P{1'b0}}});
  assign m  = RW'({margin_i, {SCALE_FRAC_BITS_P{1'b0}}});
  assign ax = RW'(ax_i);
  assign ay = RW'(ay_i);
  assign bx = RW'(bx_i);
  assign by = RW'(by_i);

  // corners are not sorted: reversed corners shrink the spans
  assign in_x_span = (p > ax - m) && (p < bx + m);
  assign in_y_span = (q > ay - m) && (q < by + m);
  assign y_band    = ((q > ay - m) && (q < ay + m)) || ((q > by - m) && (q < by + m));
  assign x_band    = ((p > ax - m) && (p < ax + m)) || ((p > bx - m) && (p < bx + m));
  assign hit       = (in_x_span && y_band) || (in_y_span && x_band);

  always_comb begin
    ctl_d          = ctl_i;
    ctl_d.rect_hit = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  assign ctl_o = ctl_q;

endmodule

// ===== sv/spht_dist.sv =====
module spht_dist import spht_pkg::*; #(
  parameter int COORD_BITS_P      = COORD_BITS,
  parameter int SCALE_FRAC_BITS_P = SCALE_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  spht_ctl_t                          ctl_i,
  input  logic [COORD_BITS_P-1:0]            px_i,
  input  logic [COORD_BITS_P-1:0]            py_i,
  input  logic [COORD_BITS_P+SCALE_W-1:0]    ax_i,
  input  logic [COORD_BITS_P+SCALE_W-1:0]    ay_i,
  input  logic [COORD_BITS_P+SCALE_W-1:0]    bx_i,
  input  logic [COORD_BITS_P+SCALE_W-1:0]    by_i,
  input  logic [2*MARGIN_W-1:0]              margin_sq_i,
  output logic                               done_o,
  output logic                               hit_o
);

  localparam int PW   = COORD_BITS_P + SCALE_W;
  localparam int SW   = PW - SCALE_FRAC_BITS_P;
  localparam int DW   = SW + 1;
  localparam int PRW  = 2 * DW;
  localparam int SUMW = PRW + 1;
  localparam int MLW  = PRW + 2 * MARGIN_W;
  localparam int CB   = (MLW + 1) / 2;

  // stage 2: truncated screen endpoints and differences
  logic [SW-1:0] axs, ays, bxs, bys;
  logic signed [DW-1:0] dx_d, dy_d, ex_d, ey_d, fx_d, fy_d;
  logic signed [DW-1:0] dx_q, dy_q, ex_q, ey_q, fx_q, fy_q;

  assign axs = ax_i[PW-1:SCALE_FRAC_BITS_P];
  assign ays = ay_i[PW-1:SCALE_FRAC_BITS_P];
  assign bxs = bx_i[PW-1:SCALE_FRAC_BITS_P];
  assign bys = by_i[PW-1:SCALE_FRAC_BITS_P];

  assign dx_d = $signed(DW'(bxs)) - $signed(DW'(axs));
  assign dy_d = $signed(DW'(bys)) - $signed(DW'(ays));
  assign ex_d = $signed(DW'(px_i)) - $signed(DW'(axs));
  assign ey_d = $signed(DW'(py_i)) - $signed(DW'(ays));
  assign fx_d = $signed(DW'(px_i)) - $signed(DW'(bxs));
  assign fy_d = $signed(DW'(py_i)) - $signed(DW'(bys));

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    ex_q <= ex_d;
    ey_q <= ey_d;
    fx_q <= fx_d;
    fy_q <= fy_d;
  end

  // stage 3: products
  spht_ctl_t ctl3_q;
  logic signed [PRW-1:0] dxdx_q, dydy_q, exdx_q, eydy_q, exdy_q, eydx_q;
  logic signed [PRW-1:0] exex_q, eyey_q, fxfx_q, fyfy_q;

  always_ff @(posedge clk_i) begin
    dxdx_q <= PRW'(dx_q) * PRW'(dx_q);
    dydy_q <= PRW'(dy_q) * PRW'(dy_q);
    exdx_q <= PRW'(ex_q) * PRW'(dx_q);
    eydy_q <= PRW'(ey_q) * PRW'(dy_q);
    exdy_q <= PRW'(ex_q) * PRW'(dy_q);
    eydx_q <= PRW'(ey_q) * PRW'(dx_q);
    exex_q <= PRW'(ex_q) * PRW'(ex_q);
    eyey_q <= PRW'(ey_q) * PRW'(ey_q);
    fxfx_q <= PRW'(fx_q) * PRW'(fx_q);
    fyfy_q <= PRW'(fy_q) * PRW'(fy_q);
  end

  // stage 4: sums and endpoint tests
  spht_ctl_t ctl4_q;
  logic signed [SUMW-1:0] len2_d, t_d, cross_d, e1_d, e2_d, mm_w;
  logic signed [SUMW-1:0] len2_q, t_q, cross_q;
  logic near1_q4, near2_q4;

  assign mm_w    = SUMW'(margin_sq_i);
  assign len2_d  = SUMW'(dxdx_q) + SUMW'(dydy_q);
  assign t_d     = SUMW'(exdx_q) + SUMW'(eydy_q);
  assign cross_d = SUMW'(exdy_q) - SUMW'(eydx_q);
  assign e1_d    = SUMW'(exex_q) + SUMW'(eyey_q);
  assign e2_d    = SUMW'(fxfx_q) + SUMW'(fyfy_q);

  always_ff @(posedge clk_i) begin
    len2_q   <= len2_d;
    t_q      <= t_d;
    cross_q  <= cross_d;
    near1_q4 <= (e1_d <= mm_w);
    near2_q4 <= (e2_d <= mm_w);
  end

  // stage 5: case select, |cross| clamp, margin^2 * len2
  spht_ctl_t ctl5_q;
  logic            t_neg, t_gt, len2_zero;
  logic [PRW-1:0]  cross_abs;
  logic [MLW-1:0]  mmlen2_d, mmlen2_q5;
  logic            sel_e1_q5, sel_e2_q5, near1_q5, near2_q5, big_q5;
  logic [CB-1:0]   cross_lo_q5;

  assign t_neg     = t_q[SUMW-1];
  assign t_gt      = (t_q > len2_q);
  assign len2_zero = (len2_q == '0);
  assign cross_abs = cross_q[SUMW-1] ? PRW'(-cross_q) : PRW'(cross_q);
  assign mmlen2_d  = MLW'(margin_sq_i) * MLW'(len2_q[PRW-1:0]);

  always_ff @(posedge clk_i) begin
    sel_e1_q5   <= len2_zero || t_neg;
    sel_e2_q5   <= t_gt;
    near1_q5    <= near1_q4;
    near2_q5    <= near2_q4;
    // |cross| >= 2^CB can never be within margin
    big_q5      <= |cross_abs[PRW-1:CB];
    cross_lo_q5 <= cross_abs[CB-1:0];
    mmlen2_q5   <= mmlen2_d;
  end

  // stage 6: cross^2
  spht_ctl_t ctl6_q;
  logic [2*CB-1:0] cross2_q6;
  logic [MLW-1:0]  mmlen2_q6;
  logic            sel_e1_q6, sel_e2_q6, near1_q6, near2_q6, big_q6;

  always_ff @(posedge clk_i) begin
    cross2_q6 <= (2*CB)'(cross_lo_q5) * (2*CB)'(cross_lo_q5);
    mmlen2_q6 <= mmlen2_q5;
    sel_e1_q6 <= sel_e1_q5;
    sel_e2_q6 <= sel_e2_q5;
    near1_q6  <= near1_q5;
    near2_q6  <= near2_q5;
    big_q6    <= big_q5;
  end

  // stage 7: pick result
  logic perp_hit, line_hit, hit_d, hit_q, done_q;

  assign perp_hit = !big_q6 && (cross2_q6 <= mmlen2_q6);
  assign line_hit = sel_e1_q6 ? near1_q6 : (sel_e2_q6 ? near2_q6 : perp_hit);
  assign hit_d    = ctl6_q.kind ? line_hit : ctl6_q.rect_hit;

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl3_q <= ctl_i;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl5_q;
      done_q <= ctl6_q.vld;
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;

  // every word entering the distance pipe leaves it through ctl3_q, ctl4_q, ctl5_q, ctl6_q and done_q
  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(ctl_i.vld, 5))
    else $error("done strobe out of step with stage 2");

  a_len2_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl4_q.vld && ctl4_q.kind) |-> !len2_q[SUMW-1])
    else $error("squared length negative");

  a_t_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl4_q.vld && ctl4_q.kind) |-> !(t_neg && t_gt))
    else $error("projection both before and past the segment");

  a_big_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl6_q.vld && ctl6_q.kind && !sel_e1_q6 && !sel_e2_q6 && big_q6) |=> !hit_o)
    else $error("clamped cross product reported a hit");

endmodule

// ===== sv/shape_pick_hit_test.sv =====
// shape_pick_hit_test: pick-point hit test against a rectangle or a line segment.
// start_i is registered in spht_scale; done_o/hit_o leave the stage 7 registers.
// Throughput: one word per cycle; busy_o stays low, the seven-stage pipe never stalls.
// The receiver cannot stall: done_o is a one-cycle strobe and must be taken at once.
// Reset (rst_ni low, async): pipe valid bits clear, hit_margin=4, x_scale=y_scale=256.
module shape_pick_hit_test import spht_pkg::*; #(
  parameter int COORD_BITS_P      = COORD_BITS,
  parameter int SCALE_FRAC_BITS_P = SCALE_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // item channel
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [COORD_BITS_P-1:0]  pick_x_i,
  input  logic [COORD_BITS_P-1:0]  pick_y_i,
  input  logic                     obj_kind_i,
  input  logic [COORD_BITS_P-1:0]  obj_x1_i,
  input  logic [COORD_BITS_P-1:0]  obj_y1_i,
  input  logic [COORD_BITS_P-1:0]  obj_x2_i,
  input  logic [COORD_BITS_P-1:0]  obj_y2_i,
  // config write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // result
  output logic                     done_o,
  output logic                     hit_o
);

  // Pipe layout:
  //   1 spht_scale : corner * scale (four C x 16 multipliers)
  //   2 spht_rect  : rectangle band compares; spht_dist: truncated endpoints, deltas
  //   3 spht_dist  : ten squared / cross products of the deltas
  //   4            : length^2, projection t, cross, endpoint distance tests
  //   5            : endpoint/perpendicular select, |cross| clamp, margin^2 * length^2
  //   6            : cross^2 on the clamped magnitude
  //   7            : final pick, output register
  // The multiplier stages set the cycle time; no stage holds more than one
  // multiplier or one add-and-compare in series.

  localparam int PW = COORD_BITS_P + SCALE_W;

  // config registers
  logic [MARGIN_W-1:0]   margin_q, margin_d;
  logic [2*MARGIN_W-1:0] margin_sq_q, margin_sq_d;
  logic [SCALE_W-1:0]    x_scale_q, x_scale_d, y_scale_q, y_scale_d;
  logic                  cfg_we, accept;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign busy_o      = 1'b0;
  assign accept      = start_i && !busy_o;

  always_comb begin
    margin_d    = margin_q;
    margin_sq_d = margin_sq_q;
    x_scale_d   = x_scale_q;
    y_scale_d   = y_scale_q;
    if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HIT_MARGIN: begin
          margin_d    = cfg_data_i[MARGIN_W-1:0];
          // squared margin kept alongside so no stage multiplies twice
          margin_sq_d = (2*MARGIN_W)'(cfg_data_i[MARGIN_W-1:0]) *
                        (2*MARGIN_W)'(cfg_data_i[MARGIN_W-1:0]);
        end
        CFG_X_SCALE: begin
          x_scale_d = cfg_data_i[SCALE_W-1:0];
        end
        CFG_Y_SCALE: begin
          y_scale_d = cfg_data_i[SCALE_W-1:0];
        end
        default: begin
          // unused index: write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q    <= MARGIN_RST;
      margin_sq_q <= MARGIN_SQ_RST;
      x_scale_q   <= SCALE_RST;
      y_scale_q   <= SCALE_RST;
    end else begin
      margin_q    <= margin_d;
      margin_sq_q <= margin_sq_d;
      x_scale_q   <= x_scale_d;
      y_scale_q   <= y_scale_d;
    end
  end

  // stage 1 outputs
  spht_ctl_t               ctl1, ctl2;
  logic [COORD_BITS_P-1:0] px1, py1;
  logic [PW-1:0]           ax1, ay1, bx1, by1;

  spht_scale #(
    .COORD_BITS_P (COORD_BITS_P)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .pick_x_i   (pick_x_i),
    .pick_y_i   (pick_y_i),
    .obj_kind_i (obj_kind_i),
    .obj_x1_i   (obj_x1_i),
    .obj_y1_i   (obj_y1_i),
    .obj_x2_i   (obj_x2_i),
    .obj_y2_i   (obj_y2_i),
    .x_scale_i  (x_scale_q),
    .y_scale_i  (y_scale_q),
    .ctl_o      (ctl1),
    .px_o       (px1),
    .py_o       (py1),
    .ax_o       (ax1),
    .ay_o       (ay1),
    .bx_o       (bx1),
    .by_o       (by1)
  );

  // rectangle test finishes in stage 2 and rides along in the control word
  spht_rect #(
    .COORD_BITS_P      (COORD_BITS_P),
    .SCALE_FRAC_BITS_P (SCALE_FRAC_BITS_P)
  ) u_rect (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl1),
    .px_i     (px1),
    .py_i     (py1),
    .ax_i     (ax1),
    .ay_i     (ay1),
    .bx_i     (bx1),
    .by_i     (by1),
    .margin_i (margin_q),
    .ctl_o    (ctl2)
  );

  spht_dist #(
    .COORD_BITS_P      (COORD_BITS_P),
    .SCALE_FRAC_BITS_P (SCALE_FRAC_BITS_P)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl2),
    .px_i        (px1),
    .py_i        (py1),
    .ax_i        (ax1),
    .ay_i        (ay1),
    .bx_i        (bx1),
    .by_i        (by1),
    .margin_sq_i (margin_sq_q),
    .done_o      (done_o),
    .hit_o       (hit_o)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import spht_pkg::*;;

  // Clock, timeout and pipe depth
  localparam int          CLK_PERIOD     = 8;
  localparam int          RESET_CYCLES   = 9;
  localparam int          PIPE_DEPTH     = 7;   // pipe stages from the spht_scale register to the output register
  localparam int unsigned TIMEOUT_CYCLES = 200_000;
  localparam int          COORD_MAX      = (1 << COORD_BITS) - 1;
  localparam int          PHASE_WORDS    = 90;

  // Object kinds as carried on obj_kind_i
  localparam logic KIND_RECT = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  // Index past the end of the register list; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // One pick request as it sits on the item ports
  typedef struct packed {
    logic                  obj_kind;
    logic [COORD_BITS-1:0] pick_x;
    logic [COORD_BITS-1:0] pick_y;
    logic [COORD_BITS-1:0] obj_x1;
    logic [COORD_BITS-1:0] obj_y1;
    logic [COORD_BITS-1:0] obj_x2;
    logic [COORD_BITS-1:0] obj_y2;
  } pick_word_t;

  typedef struct packed {
    pick_word_t word;
    logic       hit;
  } pick_expect_t;

  // Holds predicted hits in issue order; results pop the oldest one
  class hit_scoreboard;
    pick_expect_t expected_hits[$];
    int unsigned  errors;

    function int pending();
      return expected_hits.size();
    endfunction

    function void note_pick(pick_word_t w, logic hit);
      pick_expect_t e;
      e.word = w;
      e.hit  = hit;
      expected_hits.push_back(e);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_hit(logic got);
      pick_expect_t e;
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("result hit=%0b with nothing outstanding", got));
      end else begin
        e = expected_hits.pop_front();
        if (got !== e.hit) begin
          report_mismatch($sformatf(
            "hit=%0b exp %0b kind=%0d pick=(%0d,%0d) obj=(%0d,%0d)-(%0d,%0d)",
            got, e.hit, e.word.obj_kind, e.word.pick_x, e.word.pick_y,
            e.word.obj_x1, e.word.obj_y1, e.word.obj_x2, e.word.obj_y2));
        end
      end
    endtask

    task flush_leftovers();
      pick_expect_t e;
      while (expected_hits.size() != 0) begin
        e = expected_hits.pop_front();
        report_mismatch($sformatf("no result for kind=%0d pick=(%0d,%0d)",
                                  e.word.obj_kind, e.word.pick_x, e.word.pick_y));
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [COORD_BITS-1:0]   pick_x_i;
  logic [COORD_BITS-1:0]   pick_y_i;
  logic                    obj_kind_i;
  logic [COORD_BITS-1:0]   obj_x1_i;
  logic [COORD_BITS-1:0]   obj_y1_i;
  logic [COORD_BITS-1:0]   obj_x2_i;
  logic [COORD_BITS-1:0]   obj_y2_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    done_o;
  logic                    hit_o;

  shape_pick_hit_test u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .pick_x_i    (pick_x_i),
    .pick_y_i    (pick_y_i),
    .obj_kind_i  (obj_kind_i),
    .obj_x1_i    (obj_x1_i),
    .obj_y1_i    (obj_y1_i),
    .obj_x2_i    (obj_x2_i),
    .obj_y2_i    (obj_y2_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .hit_o       (hit_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  hit_scoreboard sb = new();

  // Shadow copy of the register file, updated at the write handshake edge.
  // Reset values must match the block's own reset.
  logic [MARGIN_W-1:0] margin_q = MARGIN_RST;
  logic [SCALE_W-1:0]  xscale_q = SCALE_RST;
  logic [SCALE_W-1:0]  yscale_q = SCALE_RST;

  // ---------------------------------------------------------------------------
  // Hit predictor
  // ---------------------------------------------------------------------------
  // Open interval c-m < v < c+m around an edge.
  function automatic bit in_band(longint v, longint c, longint m);
    return v > c - m && v < c + m;
  endfunction

  // Closed disc of radius m, squared compare.
  function automatic bit within_radius(longint dx, longint dy, longint m);
    longint ax;
    longint ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    return ax * ax + ay * ay <= m * m;
  endfunction

  function automatic logic predict_hit(pick_word_t w);
    longint p, q, m, ax, ay, bx, by;
    longint dx, dy, ex, ey, len2, t, cross_v;
    logic [127:0] lhs, rhs;
    if (w.obj_kind == KIND_RECT) begin
      // Rectangle: exact compare in Q.SCALE_FRAC_BITS, corners taken as given
      p  = longint'(w.pick_x) <<< SCALE_FRAC_BITS;
      q  = longint'(w.pick_y) <<< SCALE_FRAC_BITS;
      m  = longint'(margin_q) <<< SCALE_FRAC_BITS;
      ax = longint'(w.obj_x1) * longint'(xscale_q);
      bx = longint'(w.obj_x2) * longint'(xscale_q);
      ay = longint'(w.obj_y1) * longint'(yscale_q);
      by = longint'(w.obj_y2) * longint'(yscale_q);
      return (p > ax - m && p < bx + m && (in_band(q, ay, m) || in_band(q, by, m))) ||
             (q > ay - m && q < by + m && (in_band(p, ax, m) || in_band(p, bx, m)));
    end
    // Line: endpoints truncated to whole screen pixels
    ax   = (longint'(w.obj_x1) * longint'(xscale_q)) >>> SCALE_FRAC_BITS;
    bx   = (longint'(w.obj_x2) * longint'(xscale_q)) >>> SCALE_FRAC_BITS;
    ay   = (longint'(w.obj_y1) * longint'(yscale_q)) >>> SCALE_FRAC_BITS;
    by   = (longint'(w.obj_y2) * longint'(yscale_q)) >>> SCALE_FRAC_BITS;
    p    = longint'(w.pick_x);
    q    = longint'(w.pick_y);
    m    = longint'(margin_q);
    dx   = bx - ax;
    dy   = by - ay;
    ex   = p - ax;
    ey   = q - ay;
    len2 = dx * dx + dy * dy;
    t    = ex * dx + ey * dy;
    // Degenerate segment or projection before the first endpoint
    if (len2 == 0 || t < 0) begin
      return within_radius(ex, ey, m);
    end
    if (t > len2) begin
      return within_radius(p - bx, q - by, m);
    end
    // Perpendicular: cross^2 <= m^2 * len2, needs more than 64 bits
    cross_v = ex * dy - ey * dx;
    if (cross_v < 0) begin
      cross_v = -cross_v;
    end
    lhs = 128'(cross_v) * 128'(cross_v);
    rhs = 128'(m * m) * 128'(len2);
    return lhs <= rhs;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled on the rising edge, before this edge's updates
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_hit(hit_o);
    end
    if (rst_ni && start_i && !busy_o) begin
      sb.note_pick(pick_word_t'{obj_kind_i, pick_x_i, pick_y_i,
                                obj_x1_i, obj_y1_i, obj_x2_i, obj_y2_i},
                   predict_hit(pick_word_t'{obj_kind_i, pick_x_i, pick_y_i,
                                            obj_x1_i, obj_y1_i, obj_x2_i, obj_y2_i}));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
    if (v < 0) begin
      return '0;
    end
    return (v > COORD_MAX) ? COORD_BITS'(COORD_MAX) : COORD_BITS'(v);
  endfunction

  // Largest map coordinate that still lands on screen at this scale
  function automatic int map_limit(int s);
    int l;
    if (s == 0) begin
      return COORD_MAX;
    end
    l = (COORD_MAX << SCALE_FRAC_BITS) / s;
    return (l > COORD_MAX) ? COORD_MAX : l;
  endfunction

  function automatic int to_screen(int c, int s);
    return (c * s) >> SCALE_FRAC_BITS;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [COORD_BITS-1:0] extreme_coord();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return COORD_BITS'(COORD_MAX);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // Mostly objects that fit on screen with the pick point placed near an
  // edge or along the segment, so hits and near misses both show up often.
  function automatic pick_word_t random_word();
    pick_word_t w;
    int sel, lx, ly, sx1, sy1, sx2, sy2, span, f, px, py;
    logic [COORD_BITS-1:0] tmp;
    sel        = $urandom_range(0, 99);
    w.obj_kind = 1'($urandom_range(0, 1));
    w.pick_x   = COORD_BITS'($urandom);
    w.pick_y   = COORD_BITS'($urandom);
    w.obj_x1   = COORD_BITS'($urandom);
    w.obj_y1   = COORD_BITS'($urandom);
    w.obj_x2   = COORD_BITS'($urandom);
    w.obj_y2   = COORD_BITS'($urandom);
    if (sel < 15) begin
      return w;
    end
    if (sel < 25) begin
      w.pick_x = extreme_coord();
      w.pick_y = extreme_coord();
      w.obj_x1 = extreme_coord();
      w.obj_y1 = extreme_coord();
      w.obj_x2 = extreme_coord();
      w.obj_y2 = extreme_coord();
      return w;
    end
    lx = map_limit(int'(xscale_q));
    ly = map_limit(int'(yscale_q));
    w.obj_x1 = COORD_BITS'($urandom_range(0, lx));
    w.obj_x2 = COORD_BITS'($urandom_range(0, lx));
    w.obj_y1 = COORD_BITS'($urandom_range(0, ly));
    w.obj_y2 = COORD_BITS'($urandom_range(0, ly));
    if (w.obj_kind == KIND_RECT) begin
      // keep most corners ordered; the rest exercise shrunken bands
      if ($urandom_range(0, 99) < 85) begin
        if (w.obj_x1 > w.obj_x2) begin
          tmp = w.obj_x1; w.obj_x1 = w.obj_x2; w.obj_x2 = tmp;
        end
        if (w.obj_y1 > w.obj_y2) begin
          tmp = w.obj_y1; w.obj_y1 = w.obj_y2; w.obj_y2 = tmp;
        end
      end
    end else begin
      case ($urandom_range(0, 9))
        0: w.obj_x2 = w.obj_x1;                           // vertical
        1: w.obj_y2 = w.obj_y1;                           // horizontal
        2: begin w.obj_x2 = w.obj_x1; w.obj_y2 = w.obj_y1; end  // zero length
        default: ;
      endcase
    end
    sx1  = to_screen(int'(w.obj_x1), int'(xscale_q));
    sx2  = to_screen(int'(w.obj_x2), int'(xscale_q));
    sy1  = to_screen(int'(w.obj_y1), int'(yscale_q));
    sy2  = to_screen(int'(w.obj_y2), int'(yscale_q));
    span = int'(margin_q) + 2;
    f    = $urandom_range(0, 16);
    if (w.obj_kind == KIND_RECT) begin
      if ($urandom_range(0, 1)) begin
        px = sx1 + (sx2 - sx1) * f / 16 + jitter(span);
        py = ($urandom_range(0, 1) ? sy1 : sy2) + jitter(span);
      end else begin
        px = ($urandom_range(0, 1) ? sx1 : sx2) + jitter(span);
        py = sy1 + (sy2 - sy1) * f / 16 + jitter(span);
      end
    end else begin
      px = sx1 + (sx2 - sx1) * f / 16;
      py = sy1 + (sy2 - sy1) * f / 16;
      // a third stay on the interpolated point, which matters at margin 0
      if ($urandom_range(0, 2) != 0) begin
        px += jitter(span);
        py += jitter(span);
      end
    end
    w.pick_x = clamp_coord(px);
    w.pick_y = clamp_coord(py);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Presents a word and returns at the edge that takes it. start_i is left
  // high so back-to-back words need no extra NBA in the same step.
  task automatic send_word(pick_word_t w);
    start_i    <= 1'b1;
    obj_kind_i <= w.obj_kind;
    pick_x_i   <= w.pick_x;
    pick_y_i   <= w.pick_y;
    obj_x1_i   <= w.obj_x1;
    obj_y1_i   <= w.obj_y1;
    obj_x2_i   <= w.obj_x2;
    obj_y2_i   <= w.obj_y2;
    do @(posedge clk_i); while (busy_o);
  endtask

  // start_i must already be low. Reads may run ahead of this edge's pop,
  // which only lengthens the wait.
  task automatic wait_drained();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_HIT_MARGIN: margin_q = data[MARGIN_W-1:0];
      CFG_X_SCALE:    xscale_q = data[SCALE_W-1:0];
      CFG_Y_SCALE:    yscale_q = data[SCALE_W-1:0];
      default: ;  // out-of-range index is dropped
    endcase
  endtask

  // Random traffic in bursts; the idle gaps between bursts land on every pipe stage,
  // and now and then the sender holds off until the pipe has emptied.
  task automatic drive_random(int count);
    int burst;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < count; i++) begin
      send_word(random_word());
      burst--;
      if (burst == 0 && i != count - 1) begin
        start_i <= 1'b0;
        if ($urandom_range(0, 19) == 0) begin
          wait_drained();
        end else begin
          repeat ($urandom_range(1, 9)) @(posedge clk_i);
        end
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                            : $urandom_range(1, 24);
      end
    end
    start_i <= 1'b0;
  endtask

  // Registers change only with the pipe empty. Margin writes carry junk in
  // the upper data bits to check masking.
  task automatic run_phase(logic [MARGIN_W-1:0] margin, logic [SCALE_W-1:0] xs,
                           logic [SCALE_W-1:0] ys, bit poke_spare);
    wait_drained();
    write_reg(CFG_HIT_MARGIN, {(CFG_DATA_W - MARGIN_W)'($urandom), margin});
    write_reg(CFG_X_SCALE, xs);
    write_reg(CFG_Y_SCALE, ys);
    if (poke_spare || $urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
    drive_random(PHASE_WORDS);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    obj_kind_i  <= KIND_RECT;
    pick_x_i    <= '0;
    pick_y_i    <= '0;
    obj_x1_i    <= '0;
    obj_y1_i    <= '0;
    obj_x2_i    <= '0;
    obj_y2_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_HIT_MARGIN;
    cfg_data_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on reset registers (margin 4, unit scale), back to back.
    // Rectangle bands: on edge, interior, just inside and exactly at the band.
    send_word(pick_word_t'{KIND_RECT, 150, 100, 100, 100, 200, 200});
    send_word(pick_word_t'{KIND_RECT, 150, 150, 100, 100, 200, 200});
    send_word(pick_word_t'{KIND_RECT, 150, 103, 100, 100, 200, 200});
    send_word(pick_word_t'{KIND_RECT, 150, 104, 100, 100, 200, 200});
    // swapped corners shrink the spanning test
    send_word(pick_word_t'{KIND_RECT, 150, 100, 200, 200, 100, 100});
    send_word(pick_word_t'{KIND_RECT, 0, 0, 0, 0, 0, 0});
    send_word(pick_word_t'{KIND_RECT, 4095, 4095, 0, 0, 4095, 4095});
    send_word(pick_word_t'{KIND_RECT, 0, 0, 4095, 4095, 4095, 4095});
    send_word(pick_word_t'{KIND_RECT, 4095, 4095, 4095, 0, 0, 4095});
    // Lines: on the diagonal and off it
    send_word(pick_word_t'{KIND_LINE, 2048, 2048, 0, 0, 4095, 4095});
    send_word(pick_word_t'{KIND_LINE, 2048, 2060, 0, 0, 4095, 4095});
    // before the first endpoint, past the second, and perpendicular at margin
    send_word(pick_word_t'{KIND_LINE, 97, 100, 100, 100, 200, 100});
    send_word(pick_word_t'{KIND_LINE, 95, 100, 100, 100, 200, 100});
    send_word(pick_word_t'{KIND_LINE, 203, 102, 100, 100, 200, 100});
    send_word(pick_word_t'{KIND_LINE, 204, 103, 100, 100, 200, 100});
    send_word(pick_word_t'{KIND_LINE, 150, 104, 100, 100, 200, 100});
    send_word(pick_word_t'{KIND_LINE, 150, 105, 100, 100, 200, 100});
    // zero-length line falls back to the endpoint distance
    send_word(pick_word_t'{KIND_LINE, 303, 300, 300, 300, 300, 300});
    send_word(pick_word_t'{KIND_LINE, 300, 305, 300, 300, 300, 300});
    send_word(pick_word_t'{KIND_LINE, 4095, 4095, 4095, 4095, 4095, 4095});
    send_word(pick_word_t'{KIND_LINE, 0, 0, 4095, 0, 0, 4095});
    send_word(pick_word_t'{KIND_LINE, 4095, 0, 0, 4095, 4095, 0});
    start_i <= 1'b0;

    // Register sweeps: zero margin, max margin with max scale, a zero scale
    // on each axis, the smallest nonzero scale, margin 1 with unequal scales, then random settings.
    run_phase(4'd0,  16'd256,   16'd256,   1'b1);
    run_phase(4'd15, 16'd65535, 16'd65535, 1'b0);
    run_phase(4'd7,  16'd0,     16'd512,   1'b0);
    run_phase(4'd3,  16'd128,   16'd0,     1'b0);
    run_phase(4'd15, 16'd1,     16'd65535, 1'b0);
    run_phase(4'd1,  16'd300,   16'd200,   1'b0);
    repeat (4) begin
      run_phase(MARGIN_W'($urandom_range(0, 15)),
                ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom)
                                            : SCALE_W'($urandom_range(64, 1024)),
                ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom)
                                            : SCALE_W'($urandom_range(64, 1024)),
                1'b0);
    end

    // Let the pipe empty, bounded, then idle on to catch any strays
    for (int k = 0; k < 50 * PIPE_DEPTH && sb.pending() != 0; k++) begin
      @(posedge clk_i);
    end
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    sb.flush_leftovers();

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
